>>> rtl/string_hash_bucket_index_assert.svh
// Assertion macros used by the divider of the string hash bucket index RTL.
`ifndef STRING_HASH_BUCKET_INDEX_ASSERT_SVH
`define STRING_HASH_BUCKET_INDEX_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SHBI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shbi assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SHBI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shbi assertion failed");

`endif

>>> rtl/shbi_pkg.sv
// Package with constants and types for the string hash bucket index block.
`timescale 1ns / 1ps
`default_nettype none

package shbi_pkg;

   localparam int unsigned HashW   = 32;
   localparam int unsigned CharW   = 8;
   localparam int unsigned SizeW   = 16;
   localparam int unsigned StepCntW = $clog2(HashW);

   localparam logic [HashW-1:0] HashSeed  = HashW'(5381);
   localparam logic [SizeW-1:0] SizeReset = SizeW'(31);

   // Divider status seen by the top level
   typedef struct packed {
      logic busy;
      logic done;
   } shbi_div_stat_type;

endpackage

`default_nettype wire

>>> rtl/shbi_accum.sv
// Hash accumulator: acc = acc * 33 + signed char, reseeded after the final char.
`timescale 1ns / 1ps
`default_nettype none

module shbi_accum (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [shbi_pkg::CharW-1:0]  ch,
   input  wire logic                        last,
   output logic      [shbi_pkg::HashW-1:0]  hash_next
);
   import shbi_pkg::*;

   logic [HashW-1:0] acc_ff;
   logic [HashW-1:0] acc_in;
   logic [HashW-1:0] ch_ext;

   // acc * 33 is acc shifted by five plus acc; char is sign extended
   assign ch_ext    = {{(HashW-CharW){ch[CharW-1]}}, ch};
   assign hash_next = (acc_ff << 5) + acc_ff + ch_ext;

   always_comb begin
      acc_in = acc_ff;
      if (step) begin
         acc_in = last ? HashSeed : hash_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= HashSeed;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/shbi_div.sv
// Bit-serial restoring divider giving |hash| rem table size, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "string_hash_bucket_index_assert.svh"

module shbi_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [shbi_pkg::HashW-1:0]   hash,
   input  wire logic [shbi_pkg::SizeW-1:0]   divisor,
   input  wire logic                         take,
   output shbi_pkg::shbi_div_stat_type       stat,
   output logic      [shbi_pkg::SizeW-1:0]   bucket
);
   import shbi_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ABS,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [StepCntW-1:0] cnt_ff, cnt_in;
   logic [HashW-1:0]   num_ff, num_in;
   logic [SizeW-1:0]   rem_ff, rem_in;
   logic [SizeW-1:0]   dvs_ff, dvs_in;
   logic [SizeW:0]     trial;
   logic [SizeW:0]     diff;

   // One restoring step: bring in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, num_ff[HashW-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               num_in   = hash;
               dvs_in   = divisor;
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            // magnitude; the most negative value maps to 2^31 unsigned
            if (num_ff[HashW-1]) begin
               num_in = ~num_ff + HashW'(1);
            end
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            rem_in = diff[SizeW] ? trial[SizeW-1:0] : diff[SizeW-1:0];
            num_in = num_ff << 1;
            cnt_in = cnt_ff + StepCntW'(1);
            if (cnt_ff == StepCntW'(HashW-1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat   = '{busy: (state_ff != ST_IDLE), done: (state_ff == ST_DONE)};
   // zero table size gives bucket zero
   assign bucket = (dvs_ff == '0) ? '0 : rem_ff;

   `SHBI_ASSERT_NOW(a_start_idle, clock, reset, start, state_ff == ST_IDLE)
   `SHBI_ASSERT_NOW(a_rem_below, clock, reset, (state_ff == ST_DONE) && (dvs_ff != '0),
                    rem_ff < dvs_ff)
   `SHBI_ASSERT_NEXT(a_run_ends, clock, reset,
                     (state_ff == ST_RUN) && (cnt_ff == StepCntW'(HashW-1)),
                     state_ff == ST_DONE)
   `SHBI_ASSERT_NOW(a_take_done, clock, reset, take, state_ff == ST_DONE)

endmodule

`default_nettype wire

>>> rtl/string_hash_bucket_index.sv
// Top level of the string hash bucket index block: handshakes, config and result register.
//
//   port group   direction  words
//   req_*        in         one character per word, req_last on the final one
//   rsp_*        out        one bucket index per key
//   csr_*        in         table size write, 16 bits
//
// A character that is not final is folded into the hash when accepted. A final
// character starts the serial divider: a magnitude step, one remainder bit per
// step for each of the 32 hash bits, and a move of the bucket into the result
// register. req_stall is high from a final character until its bucket enters the
// result register; a word waiting there does not stall characters of the next
// key. Reset is synchronous and returns the accumulator to 5381 and the table
// size to 31.
`timescale 1ns / 1ps
`default_nettype none

module string_hash_bucket_index (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [shbi_pkg::CharW-1:0]  req_ch,
   input  wire logic                        req_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [shbi_pkg::SizeW-1:0]  rsp_bucket,
   input  wire logic                        csr_wr_en,
   input  wire logic [shbi_pkg::SizeW-1:0]  csr_wr_data
);
   import shbi_pkg::*;

   logic [SizeW-1:0]  bucket_cnt_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SizeW-1:0]  rsp_bucket_ff, rsp_bucket_in;
   logic              req_take;
   logic              div_take;
   logic [HashW-1:0]  hash_next;
   logic [SizeW-1:0]  div_bucket;
   shbi_div_stat_type div_stat;

   // input word accepted
   assign req_stall = div_stat.busy;
   assign req_take  = req_valid && !req_stall;

   shbi_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .step      (req_take),
      .ch        (req_ch),
      .last      (req_last),
      .hash_next (hash_next)
   );

   shbi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (req_take && req_last),
      .hash    (hash_next),
      .divisor (bucket_cnt_ff),
      .take    (div_take),
      .stat    (div_stat),
      .bucket  (div_bucket)
   );

   // result register loads when empty or being drained
   assign div_take = div_stat.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_bucket_in = rsp_bucket_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (div_take) begin
         rsp_valid_in  = 1'b1;
         rsp_bucket_in = div_bucket;
      end
   end

   // config register and result control
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_cnt_ff <= SizeReset;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            bucket_cnt_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_bucket_ff <= rsp_bucket_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_bucket = rsp_bucket_ff;

endmodule

`default_nettype wire

>>> dv/string_hash_bucket_index_tb.sv
// Self-checking testbench for the string hash bucket index block.
`timescale 1ns / 1ps

module string_hash_bucket_index_tb;

   import shbi_pkg::*;

   localparam int IdleCycles = 48;   // divider plus result register, with margin
   localparam int HoldCycles = 300;  // long receiver hold-off for the fill-up test
   localparam int RandPhases = 9;
   localparam int PhaseChars = 100;

   // DUT ports
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [CharW-1:0] req_ch = '0;
   logic             req_last = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [SizeW-1:0] rsp_bucket;
   logic             csr_wr_en = 1'b0;
   logic [SizeW-1:0] csr_wr_data = '0;

   // hash model state and expected buckets
   logic [HashW-1:0] hash_acc = HashSeed;
   logic [SizeW-1:0] bucket_count = SizeReset;
   logic [SizeW-1:0] bucket_due [$];
   logic [SizeW-1:0] bucket_want;

   // sender and receiver pacing
   int  burst_left = 0;
   bit  sender_steady = 1'b0;
   bit  hold_req = 1'b0;
   int  hold_left = 0;
   int  pattern_left = 0;
   int  stall_pct = 0;

   // run statistics
   int  fail_count = 0;
   int  chars_sent = 0;
   int  keys_sent = 0;
   int  size_writes = 0;
   int  buckets_checked = 0;

   string_hash_bucket_index dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_ch      (req_ch),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_bucket  (rsp_bucket),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // |acc rem size| with a zero size giving bucket 0
   function automatic logic [SizeW-1:0] bucket_for(logic [HashW-1:0] acc,
                                                   logic [SizeW-1:0] size);
      logic [HashW-1:0] mag;
      if (size == '0)
         return '0;
      mag = acc[HashW-1] ? (~acc + 32'd1) : acc;
      return SizeW'(mag % {16'd0, size});
   endfunction

   // fold one accepted character into the hash; a final one yields a bucket
   task automatic hash_fold_char(input logic [CharW-1:0] ch, input logic fin);
      hash_acc = hash_acc * 32'd33 + {{24{ch[CharW-1]}}, ch};
      chars_sent++;
      if (fin) begin
         bucket_due = {bucket_due, bucket_for(hash_acc, bucket_count)};
         hash_acc = HashSeed;
         keys_sent++;
      end
   endtask

   // seven characters whose hash from the seed lands exactly on target
   function automatic logic [55:0] key_for_hash(logic [HashW-1:0] target);
      logic [HashW-1:0] pw;
      logic [HashW-1:0] base;
      longint           rest;
      longint           r;
      logic [55:0]      chars;
      int               i;
      pw = 32'd1;
      for (i = 0; i < 7; i++)
         pw = pw * 32'd33;
      base = HashSeed * pw;
      rest = {32'd0, target - base};
      // base-33 digits, low ones kept in 1..33, top one absorbs the rest
      for (i = 6; i >= 1; i--) begin
         r = rest % 33;
         if (r == 0)
            r = 33;
         chars[8*i +: 8] = r[7:0];
         rest = (rest - r) / 33;
      end
      chars[7:0] = rest[7:0];
      return chars;
   endfunction

   // send one character word, with random gaps between bursts unless sender_steady is set
   task automatic send_char(input logic [CharW-1:0] ch, input logic fin);
      int gap;
      if (!sender_steady && burst_left == 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      req_ch    = ch;
      req_last  = fin;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      hash_fold_char(ch, fin);
      @(negedge clock);
      if (burst_left > 0)
         burst_left--;
   endtask

   task automatic send_target_key(input logic [HashW-1:0] target);
      logic [55:0] chars;
      int          i;
      chars = key_for_hash(target);
      for (i = 0; i < 7; i++)
         send_char(chars[8*i +: 8], i == 6);
   endtask

   // block quiet: no bucket outstanding and the divider surely done
   task automatic wait_idle();
      req_valid = 1'b0;
      while (bucket_due.size() != 0)
         @(negedge clock);
      repeat (IdleCycles) @(negedge clock);
   endtask

   task automatic write_table_size(input logic [SizeW-1:0] size);
      wait_idle();
      csr_wr_data = size;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en    = 1'b0;
      bucket_count = size;
      size_writes++;
   endtask

   // single characters and sign boundary under the reset table size
   task automatic test_default_size();
      send_char(8'h01, 1'b1);
      send_char(8'hFF, 1'b1);
      send_char(8'h7F, 1'b0);
      send_char(8'h80, 1'b1);
   endtask

   // a zero byte is an ordinary character, not an end of key
   task automatic test_zero_char();
      send_char(8'h00, 1'b0);
      send_char(8'h41, 1'b1);
   endtask

   // most negative and most positive hash values
   task automatic test_extreme_hashes();
      send_target_key(32'h8000_0000);
      send_target_key(32'h7FFF_FFFF);
   endtask

   // largest, smallest and zero table size
   task automatic test_size_extremes();
      write_table_size(16'hFFFF);
      send_char(8'h80, 1'b1);
      write_table_size(16'd1);
      send_char(8'h5A, 1'b1);
      write_table_size(16'd0);
      send_char(8'h33, 1'b1);
   endtask

   // size change between characters of one key keeps the partial hash
   task automatic test_config_mid_key();
      write_table_size(16'd1000);
      send_char(8'h61, 1'b0);
      send_char(8'h62, 1'b0);
      write_table_size(16'd777);
      send_char(8'h63, 1'b1);
   endtask

   // receiver holds off long while the sender keeps pushing keys
   task automatic test_backpressure();
      int k;
      write_table_size(16'd4093);
      sender_steady = 1'b1;
      hold_req      = 1'b1;
      for (k = 0; k < 10; k++) begin
         send_char(8'($urandom_range(1, 255)), 1'b0);
         send_char(8'($urandom_range(1, 255)), 1'b1);
      end
      sender_steady = 1'b0;
   endtask

   // random keys over a series of table sizes
   task automatic test_random_keys();
      int phase;
      int sent;
      int len;
      int i;
      int pick;
      for (phase = 0; phase < RandPhases; phase++) begin
         pick = $urandom_range(0, 7);
         case (pick)
            0: write_table_size(16'd1);
            1: write_table_size(16'hFFFF);
            2: write_table_size(16'd2);
            3, 4: write_table_size(16'($urandom_range(1, 300)));
            default: write_table_size(16'($urandom_range(1, 65535)));
         endcase
         sent = 0;
         while (sent < PhaseChars) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
               len = $urandom_range(1, 6);
            else if (pick < 19)
               len = $urandom_range(7, 16);
            else
               len = $urandom_range(17, 40);
            for (i = 0; i < len; i++)
               send_char(8'($urandom_range(1, 255)), i == len - 1);
            sent += len;
         end
      end
   endtask

   // receiver stall pattern, with a long counted hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HoldCycles;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 60;
               default: stall_pct = 90;
            endcase
            pattern_left = $urandom_range(16, 160);
         end
         pattern_left--;
         rsp_stall = ($urandom_range(0, 99) < stall_pct);
      end
   end

   // compare each accepted bucket word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bucket_due.size() == 0) begin
            $error("unexpected bucket word: bucket %0d", rsp_bucket);
            fail_count++;
         end else begin
            bucket_want = bucket_due.pop_front();
            buckets_checked++;
            if (rsp_bucket !== bucket_want) begin
               $error("bucket mismatch: expected %0d, actual %0d", bucket_want, rsp_bucket);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_size();
      test_zero_char();
      test_extreme_hashes();
      test_size_extremes();
      test_config_mid_key();
      test_backpressure();
      test_random_keys();
      wait_idle();

      $display("Sent %0d keys (%0d characters) across %0d table size writes,",
               keys_sent, chars_sent, size_writes);
      $display("bursty input, random output stalls, one long hold-off; %0d buckets checked.",
               buckets_checked);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
